// File: design/brp_pkg.sv
// Shared types and constants for the adaptive two-bit branch predictor.
// No dependencies; imported by the top level, brp_ctrl and brp_checker.
`default_nettype none

package brp_pkg;

  localparam int unsigned PC_W        = 20;
  localparam int unsigned CTR_W       = 2;
  localparam int unsigned PERIOD_W    = 24;
  localparam int unsigned CFG_IDX_W   = 1;
  localparam int unsigned CFG_DATA_W  = 24;

  localparam int unsigned BHT_BITS_DEF   = 12;
  localparam int unsigned MAP_BITS_DEF   = 4;
  localparam int unsigned COUNT_BITS_DEF = 24;

  localparam logic [CTR_W-1:0]    CTR_MAX         = 2'd3;
  localparam logic [CTR_W-1:0]    CTR_MIN         = 2'd0;
  localparam logic [CTR_W-1:0]    INIT_STATE_RST  = 2'd2;
  localparam logic [PERIOD_W-1:0] REMAP_PERIOD_RST = 24'd1024;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_INIT_STATE   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_REMAP_PERIOD = 1'b1;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_RMP,
    S_CTR,
    S_UPD
  } brp_state_t;

  typedef struct packed {
    logic accept;
    logic remap_req;
    logic cfg_init_wr;
    logic init_last;
    logic sweep_last;
  } brp_sts_t;

  typedef struct packed {
    logic busy;
    logic init_run;
    logic sweep_run;
    logic ctr_stage;
    logic upd_stage;
  } brp_ctl_t;

endpackage

`default_nettype wire

// File: design/adaptive_two_bit_branch_predictor.sv
// Top level of the adaptive two-bit branch predictor: datapath around three RAMs.
// Depends on brp_pkg, brp_ram and brp_ctrl.
`default_nettype none

// A resolved branch request is taken when start is high and busy is low. Each
// request yields one result, shown for exactly one cycle with out_strobe; the
// receiver cannot stall it. An ordinary request reads the counter RAM as it is
// accepted and the prediction map and outcome count RAMs in S_CTR; the counter
// and count write-backs of S_UPD overlap the counter read of the next request,
// which may be accepted in S_UPD. The result is registered from S_UPD. Every
// remap_period-th request first runs a sweep over all 4 * 2^MAP_BITS map slots,
// one per cycle, with busy high. After reset, and after every write of
// initial_counter_state, busy stays high while the counter RAM is loaded one
// entry per cycle. Configuration writes must come only while no request is in
// flight and none is being accepted in the same cycle. A counter read that hits
// the entry being written back is served by forwarding.
module adaptive_two_bit_branch_predictor
  import brp_pkg::*;
#(
  parameter int unsigned BHT_BITS   = BHT_BITS_DEF,
  parameter int unsigned MAP_BITS   = MAP_BITS_DEF,
  parameter int unsigned COUNT_BITS = COUNT_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  output logic                       busy,
  input  wire logic [PC_W-1:0]       in_branch_pc,
  input  wire logic                  in_branch_taken,
  output logic                       out_strobe,
  output logic                       out_predicted_taken,
  output logic                       out_mispredicted,
  output logic [CTR_W-1:0]           out_counter_state,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int unsigned SLOT_BITS = MAP_BITS + CTR_W;
  localparam int unsigned NSLOTS    = 1 << SLOT_BITS;
  localparam int unsigned BHT_SIZE  = 1 << BHT_BITS;
  localparam int unsigned EXT_W     = BHT_BITS + MAP_BITS;
  localparam int unsigned CNT_W     = 2 * COUNT_BITS;

  brp_sts_t sts;
  brp_ctl_t ctl;

  logic accept;

  // Configuration registers.
  logic [CTR_W-1:0]    init_state_r;
  logic [PERIOD_W-1:0] period_r;
  logic                cfg_init_wr;

  // Request registers.
  logic [BHT_BITS-1:0] idx_r;
  logic                taken_r;
  logic [CTR_W-1:0]    ctr_cur_r;
  logic [SLOT_BITS-1:0] slot_r;
  logic                fwd_r, fwd_nxt;
  logic [CTR_W-1:0]    fwd_val_r;

  logic [PERIOD_W-1:0] bc_r, bc_nxt, bc_inc;
  logic                remap_req;

  logic [BHT_BITS-1:0]  init_cnt_r, init_cnt_nxt;
  logic [SLOT_BITS:0]   sw_cnt_r, sw_cnt_nxt, sw_dec;
  logic [SLOT_BITS-1:0] sw_prev;
  logic                 sw_wr;

  logic [NSLOTS-1:0] map_vld_r;
  logic [NSLOTS-1:0] cnt_vld_r;

  // RAM ports.
  logic                ctr_we;
  logic [BHT_BITS-1:0] ctr_waddr, ctr_raddr, in_idx;
  logic [CTR_W-1:0]    ctr_wdata, ctr_rdata;
  logic [SLOT_BITS-1:0] slot_raddr;
  logic                map_rdata, map_wdata;
  logic [CNT_W-1:0]    cnt_rdata, cnt_wdata;

  // Lookup and update logic.
  logic [CTR_W-1:0]     ctr_now, ctr_upd;
  logic [SLOT_BITS-1:0] slot_now;
  logic                 pred;
  logic [CNT_W-1:0]     cnt_word;
  logic [COUNT_BITS-1:0] cnt_nt, cnt_tk, cnt_sel, cnt_inc;

  // Sweep logic.
  logic [CNT_W-1:0]      sw_word;
  logic [COUNT_BITS-1:0] sw_nt, sw_tk;
  logic                  sw_old;

  logic out_pred_r, out_mis_r, out_strobe_r;
  logic [CTR_W-1:0] out_ctr_r;

  assign busy        = ctl.busy;
  assign accept      = start && !ctl.busy;
  assign cfg_init_wr = cfg_we && (cfg_index == CFG_INIT_STATE);
  assign in_idx      = in_branch_pc[BHT_BITS-1:0];

  // The period counter advances on every accepted request; the map is rebuilt
  // first when the count reaches the period, or wraps to zero.
  assign bc_inc    = bc_r + 1'b1;
  assign remap_req = (bc_inc >= period_r) || (bc_inc == '0);

  always_comb begin
    bc_nxt = bc_r;
    if (accept) begin
      bc_nxt = remap_req ? '0 : bc_inc;
    end
  end

  assign sts.accept      = accept;
  assign sts.remap_req   = remap_req;
  assign sts.cfg_init_wr = cfg_init_wr;
  assign sts.init_last   = (init_cnt_r == BHT_BITS'(BHT_SIZE - 1));
  assign sts.sweep_last  = (sw_cnt_r == (SLOT_BITS + 1)'(NSLOTS));

  brp_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .sts   (sts),
    .ctl   (ctl)
  );

  // Load sweep over the counter RAM, restarted by every write of the
  // initial state register.
  always_comb begin
    init_cnt_nxt = '0;
    if (ctl.init_run && !cfg_init_wr) begin
      init_cnt_nxt = init_cnt_r + 1'b1;
    end
  end

  // Map sweep: the read for slot k is issued while slot k-1 is written back.
  assign sw_cnt_nxt = ctl.sweep_run ? (sw_cnt_r + 1'b1) : '0;
  assign sw_dec     = sw_cnt_r - 1'b1;
  assign sw_prev    = sw_dec[SLOT_BITS-1:0];
  assign sw_wr      = ctl.sweep_run && (sw_cnt_r != '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      init_state_r <= INIT_STATE_RST;
      period_r     <= REMAP_PERIOD_RST;
      bc_r         <= '0;
      init_cnt_r   <= '0;
      sw_cnt_r     <= '0;
      fwd_r        <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      if (cfg_init_wr) begin
        init_state_r <= cfg_wdata[CTR_W-1:0];
      end
      if (cfg_we && (cfg_index == CFG_REMAP_PERIOD)) begin
        period_r <= cfg_wdata[PERIOD_W-1:0];
      end
      bc_r         <= bc_nxt;
      init_cnt_r   <= init_cnt_nxt;
      sw_cnt_r     <= sw_cnt_nxt;
      fwd_r        <= fwd_nxt;
      out_strobe_r <= ctl.upd_stage;
    end
  end

  // Valid bits stand in for the reset contents of the map and count RAMs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      map_vld_r <= '0;
      cnt_vld_r <= '0;
    end else begin
      if (sw_wr) begin
        map_vld_r[sw_prev] <= 1'b1;
      end
      if (ctl.sweep_run && sts.sweep_last) begin
        cnt_vld_r <= '0;
      end else if (ctl.upd_stage) begin
        cnt_vld_r[slot_r] <= 1'b1;
      end
    end
  end

  // Counter RAM. A request accepted while the previous one writes back reads
  // the old value, so a hit on the same entry is forwarded from the update.
  assign ctr_raddr = accept ? in_idx : idx_r;
  assign ctr_we    = ctl.init_run || ctl.upd_stage;
  assign ctr_waddr = ctl.init_run ? init_cnt_r : idx_r;
  assign ctr_wdata = ctl.init_run ? init_state_r : ctr_upd;
  assign fwd_nxt   = ctl.upd_stage && accept && !remap_req && (in_idx == idx_r);

  brp_ram #(
    .WIDTH (CTR_W),
    .DEPTH (BHT_SIZE)
  ) u_ctr_ram (
    .clk   (clk),
    .we    (ctr_we),
    .waddr (ctr_waddr),
    .wdata (ctr_wdata),
    .raddr (ctr_raddr),
    .rdata (ctr_rdata)
  );

  // The map slot is the low MAP_BITS of the counter index above the counter value.
  assign ctr_now    = fwd_r ? fwd_val_r : ctr_rdata;
  assign slot_now   = SLOT_BITS'({EXT_W'(idx_r), ctr_now});
  assign slot_raddr = ctl.sweep_run ? sw_cnt_r[SLOT_BITS-1:0] : slot_now;

  always_ff @(posedge clk) begin
    if (accept) begin
      idx_r   <= in_idx;
      taken_r <= in_branch_taken;
    end
    if (ctl.ctr_stage) begin
      ctr_cur_r <= ctr_now;
      slot_r    <= slot_now;
    end
    fwd_val_r <= ctr_upd;
  end

  // Majority vote per slot; a tie keeps the old prediction.
  assign sw_word = cnt_vld_r[sw_prev] ? cnt_rdata : '0;
  assign sw_nt   = sw_word[COUNT_BITS-1:0];
  assign sw_tk   = sw_word[CNT_W-1:COUNT_BITS];
  assign sw_old  = map_vld_r[sw_prev] ? map_rdata : sw_prev[1];

  always_comb begin
    if (sw_tk > sw_nt) begin
      map_wdata = 1'b1;
    end else if (sw_tk < sw_nt) begin
      map_wdata = 1'b0;
    end else begin
      map_wdata = sw_old;
    end
  end

  brp_ram #(
    .WIDTH (1),
    .DEPTH (NSLOTS)
  ) u_map_ram (
    .clk   (clk),
    .we    (sw_wr),
    .waddr (sw_prev),
    .wdata (map_wdata),
    .raddr (slot_raddr),
    .rdata (map_rdata)
  );

  // Saturating increment of the outcome count of the slot that was used.
  assign cnt_word  = cnt_vld_r[slot_r] ? cnt_rdata : '0;
  assign cnt_nt    = cnt_word[COUNT_BITS-1:0];
  assign cnt_tk    = cnt_word[CNT_W-1:COUNT_BITS];
  assign cnt_sel   = taken_r ? cnt_tk : cnt_nt;
  assign cnt_inc   = (&cnt_sel) ? cnt_sel : (cnt_sel + 1'b1);
  assign cnt_wdata = taken_r ? {cnt_inc, cnt_nt} : {cnt_tk, cnt_inc};

  brp_ram #(
    .WIDTH (CNT_W),
    .DEPTH (NSLOTS)
  ) u_cnt_ram (
    .clk   (clk),
    .we    (ctl.upd_stage),
    .waddr (slot_r),
    .wdata (cnt_wdata),
    .raddr (slot_raddr),
    .rdata (cnt_rdata)
  );

  // Prediction for the current counter value; unwritten slots read as the
  // reset pattern, predicted taken for the two upper counter values.
  assign pred = map_vld_r[slot_r] ? map_rdata : slot_r[1];

  always_comb begin
    ctr_upd = ctr_cur_r;
    if (taken_r) begin
      if (ctr_cur_r != CTR_MAX) begin
        ctr_upd = ctr_cur_r + 1'b1;
      end
    end else begin
      if (ctr_cur_r != CTR_MIN) begin
        ctr_upd = ctr_cur_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.upd_stage) begin
      out_pred_r <= pred;
      out_mis_r  <= pred ^ taken_r;
      out_ctr_r  <= ctr_cur_r;
    end
  end

  assign out_strobe          = out_strobe_r;
  assign out_predicted_taken = out_pred_r;
  assign out_mispredicted    = out_mis_r;
  assign out_counter_state   = out_ctr_r;

endmodule

`default_nettype wire

// File: design/brp_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module brp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: design/brp_ctrl.sv
// Sequencer of the branch predictor: counter load, map recomputation, lookup, update.
// Depends on brp_pkg.
`default_nettype none

module brp_ctrl
  import brp_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire brp_sts_t sts,
  output brp_ctl_t      ctl
);

  brp_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_INIT: begin
        if (sts.cfg_init_wr) begin
          state_nxt = S_INIT;
        end else if (sts.init_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_RMP: begin
        if (sts.sweep_last) begin
          state_nxt = S_CTR;
        end
      end
      S_CTR: begin
        state_nxt = S_UPD;
      end
      S_IDLE, S_UPD: begin
        if (sts.cfg_init_wr) begin
          state_nxt = S_INIT;
        end else if (sts.accept) begin
          state_nxt = sts.remap_req ? S_RMP : S_CTR;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_INIT;
      end
    endcase
  end

  always_comb begin
    ctl = '0;
    case (state_r)
      S_INIT: begin
        ctl.busy     = 1'b1;
        ctl.init_run = 1'b1;
      end
      S_RMP: begin
        ctl.busy      = 1'b1;
        ctl.sweep_run = 1'b1;
      end
      S_CTR: begin
        ctl.busy      = 1'b1;
        ctl.ctr_stage = 1'b1;
      end
      S_UPD: begin
        ctl.upd_stage = 1'b1;
      end
      S_IDLE: begin
        ctl.busy = 1'b0;
      end
      default: begin
        ctl.busy = 1'b1;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: design/brp_checker.sv
// Port-level assertions for the adaptive two-bit branch predictor, bound to the top.
// Depends on brp_pkg and adaptive_two_bit_branch_predictor.
`default_nettype none

module brp_checker
  import brp_pkg::*;
(
  input wire logic                  clk,
  input wire logic                  rst_n,
  input wire logic                  start,
  input wire logic                  busy,
  input wire logic                  out_strobe,
  input wire logic                  out_predicted_taken,
  input wire logic                  out_mispredicted,
  input wire logic [CTR_W-1:0]      out_counter_state
);

  logic accept;
  assign accept = start && !busy;

  // Result strobes never come in consecutive cycles.
  a_strobe_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe)
    else $error("result strobes in consecutive cycles");

  // An accepted request always makes the block busy in the following cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy)
    else $error("block not busy after a request");

  // A result follows a cycle in which the block could take a request.
  a_strobe_after_ready: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(!busy))
    else $error("result without a preceding update cycle");

  // No result strobe comes so soon after an accept that S_CTR and S_UPD could not both lie between them.
  a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> ##1 !out_strobe)
    else $error("result too early after a request");

  // A result carries known values in every field.
  a_result_known: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> !$isunknown({out_predicted_taken, out_mispredicted, out_counter_state}))
    else $error("result with unknown fields");

endmodule

bind adaptive_two_bit_branch_predictor brp_checker u_brp_checker (.*);

`default_nettype wire
